FILE: hw/rtl/velocity_cap_with_edge_accel_core_assert.svh
// assertion macros used by the checker file of the velocity cap block
`ifndef VELOCITY_CAP_WITH_EDGE_ACCEL_CORE_ASSERT_SVH
`define VELOCITY_CAP_WITH_EDGE_ACCEL_CORE_ASSERT_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define VCEA_ASSERT_NOW(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("vcea check failed");

// next-cycle implication, sampled on clock, off while reset is high
`define VCEA_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("vcea check failed");

`endif

FILE: hw/rtl/vcea_pkg.sv
// shared widths, constants and unit interface structs of the velocity cap block
package vcea_pkg;

   localparam int VALUE_WIDTH = 32;
   // magnitude of a difference of two values
   localparam int MAG_WIDTH   = VALUE_WIDTH + 1;
   // magnitude times |accel|
   localparam int PROD_WIDTH  = MAG_WIDTH + VALUE_WIDTH;
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(VALUE_WIDTH - 1);

   localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   // register file: one 32-bit register per word
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_INDEX_LSB  = 2;
   localparam int CSR_INDEX_WIDTH = CSR_ADDR_WIDTH - CSR_INDEX_LSB;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_VELOCITY_CAP = CSR_INDEX_WIDTH'(0);

   typedef struct packed {
      logic                   start;
      logic [MAG_WIDTH-1:0]   multiplicand;
      logic [VALUE_WIDTH-1:0] multiplier;
   } mul_ctl_type;

   typedef struct packed {
      logic                  done;
      logic [PROD_WIDTH-1:0] product;
   } mul_status_type;

   typedef struct packed {
      logic                  start;
      logic                  neg;
      logic [PROD_WIDTH-1:0] dividend;
      logic [MAG_WIDTH-1:0]  divisor;
   } div_ctl_type;

   typedef struct packed {
      logic                   done;
      logic [VALUE_WIDTH-1:0] quotient;
   } div_status_type;

endpackage

FILE: hw/rtl/vcea_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
module vcea_mul (
   input  logic                     clock,
   input  logic                     reset,
   input  vcea_pkg::mul_ctl_type    mul_ctl,
   output vcea_pkg::mul_status_type mul_status
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [vcea_pkg::CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [vcea_pkg::MAG_WIDTH-1:0]   a_ff, a_in;
   logic [vcea_pkg::MAG_WIDTH-1:0]   acc_ff, acc_in;
   logic [vcea_pkg::VALUE_WIDTH-1:0] lo_ff, lo_in;
   logic [vcea_pkg::MAG_WIDTH:0]     sum;

   always_comb begin
      sum     = {1'b0, acc_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      acc_in  = acc_ff;
      lo_in   = lo_ff;
      if (mul_ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = mul_ctl.multiplicand;
         acc_in  = '0;
         lo_in   = mul_ctl.multiplier;
      end else if (busy_ff) begin
         // low product bits shift in where multiplier bits shift out
         acc_in = sum[vcea_pkg::MAG_WIDTH:1];
         lo_in  = {sum[0], lo_ff[vcea_pkg::VALUE_WIDTH-1:1]};
         cnt_in = cnt_ff + vcea_pkg::CNT_WIDTH'(1);
         if (cnt_ff == vcea_pkg::CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      acc_ff <= acc_in;
      lo_ff  <= lo_in;
   end

   assign mul_status.done    = done_ff;
   assign mul_status.product = {acc_ff, lo_ff};

endmodule

FILE: hw/rtl/vcea_div.sv
// restoring bit-serial divider with signed saturation, zero on a zero divisor
module vcea_div (
   input  logic                     clock,
   input  logic                     reset,
   input  vcea_pkg::div_ctl_type    div_ctl,
   output vcea_pkg::div_status_type div_status
);

   logic                             busy_ff, busy_in;
   logic                             fin_ff, fin_in;
   logic                             done_ff, done_in;
   logic [vcea_pkg::CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [vcea_pkg::MAG_WIDTH-1:0]   rem_ff, rem_in;
   logic [vcea_pkg::VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [vcea_pkg::MAG_WIDTH-1:0]   den_ff, den_in;
   logic                             neg_ff, neg_in;
   logic                             ovf_ff, ovf_in;
   logic                             zero_ff, zero_in;
   logic [vcea_pkg::VALUE_WIDTH-1:0] result_ff, result_in;

   logic [vcea_pkg::MAG_WIDTH-1:0]   top_part;
   logic [vcea_pkg::MAG_WIDTH:0]     shifted;
   logic [vcea_pkg::MAG_WIDTH:0]     diff;
   logic                             fit;
   logic                             pos_sat;
   logic                             neg_sat;

   always_comb begin
      top_part = div_ctl.dividend[vcea_pkg::PROD_WIDTH-1:vcea_pkg::VALUE_WIDTH];
      shifted  = {rem_ff, quo_ff[vcea_pkg::VALUE_WIDTH-1]};
      diff     = shifted - {1'b0, den_ff};
      fit      = (shifted >= {1'b0, den_ff});
      pos_sat  = ovf_ff || quo_ff[vcea_pkg::VALUE_WIDTH-1];
      neg_sat  = ovf_ff || (quo_ff[vcea_pkg::VALUE_WIDTH-1] &&
                 (|quo_ff[vcea_pkg::VALUE_WIDTH-2:0]));

      busy_in   = busy_ff;
      fin_in    = 1'b0;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      den_in    = den_ff;
      neg_in    = neg_ff;
      ovf_in    = ovf_ff;
      zero_in   = zero_ff;
      result_in = result_ff;

      if (div_ctl.start) begin
         // quotient at or above 2^width is flagged here and saturated at the end
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = top_part;
         quo_in  = div_ctl.dividend[vcea_pkg::VALUE_WIDTH-1:0];
         den_in  = div_ctl.divisor;
         neg_in  = div_ctl.neg;
         ovf_in  = (top_part >= div_ctl.divisor);
         zero_in = (div_ctl.divisor == '0);
      end else if (busy_ff) begin
         rem_in = fit ? diff[vcea_pkg::MAG_WIDTH-1:0] : shifted[vcea_pkg::MAG_WIDTH-1:0];
         quo_in = {quo_ff[vcea_pkg::VALUE_WIDTH-2:0], fit};
         cnt_in = cnt_ff + vcea_pkg::CNT_WIDTH'(1);
         if (cnt_ff == vcea_pkg::CNT_LAST) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
         if (zero_ff) begin
            result_in = '0;
         end else if (neg_ff) begin
            result_in = neg_sat ? vcea_pkg::VALUE_MIN : (~quo_ff + vcea_pkg::VALUE_WIDTH'(1));
         end else begin
            result_in = pos_sat ? vcea_pkg::VALUE_MAX : quo_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      den_ff    <= den_in;
      neg_ff    <= neg_in;
      ovf_ff    <= ovf_in;
      zero_ff   <= zero_in;
      result_ff <= result_in;
   end

   assign div_status.done     = done_ff;
   assign div_status.quotient = result_ff;

endmodule

FILE: hw/rtl/velocity_cap_with_edge_accel_core.sv
// top level of the velocity cap block with edge acceleration repair
//
// trajectory points come in on req_ in order and leave on rsp_ one point late,
// since each point is judged against its successor. a velocity above the cap
// register is clipped to the cap; a point inside a capped run gets zero
// acceleration; a point next to the edge of a run gets dv_new * max(|a|,1) /
// |dv_orig|, truncated toward zero and saturated; a point marked last leaves
// right behind its predecessor with zero acceleration and out_last set. after
// the first point of a trajectory the block stays idle and can take the next
// request in the cycle after; a plain point passes the held state, a lone last
// point the last state, and a last point behind a held one passes both. a
// request that meets a run edge runs the shift-add multiplier and then the
// restoring divider, both one bit per cycle, with operand load and quotient
// pickup, then held (and last when it ends the trajectory) for output. held
// and last wait while rsp_stall holds a waiting result. req_stall stays high
// until the request's results sit in the output register, which holds a
// result while the next request is taken. the cap register sits at byte
// address 0 and resets to the largest positive value; write it only between
// requests, and a point that is held at that time is judged by the new cap
module velocity_cap_with_edge_accel_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [vcea_pkg::VALUE_WIDTH-1:0] req_point_velocity,
   input  logic signed [vcea_pkg::VALUE_WIDTH-1:0] req_point_accel,
   input  logic                                   req_point_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [vcea_pkg::VALUE_WIDTH-1:0] rsp_out_velocity,
   output logic signed [vcea_pkg::VALUE_WIDTH-1:0] rsp_out_accel,
   output logic                                   rsp_out_last,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [vcea_pkg::CSR_ADDR_WIDTH-1:0]    paddr,
   input  logic [vcea_pkg::VALUE_WIDTH-1:0]       pwdata,
   output logic [vcea_pkg::VALUE_WIDTH-1:0]       prdata,
   output logic                                   pready
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_HELD = 5'b01000,
      ST_LAST = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // cap register
   logic signed [vcea_pkg::VALUE_WIDTH-1:0] cap_ff, cap_in;

   // point waiting for its successor, kept as it arrived
   logic                                    held_valid_ff, held_valid_in;
   logic signed [vcea_pkg::VALUE_WIDTH-1:0] held_velocity_ff, held_velocity_in;
   logic signed [vcea_pkg::VALUE_WIDTH-1:0] held_accel_ff, held_accel_in;

   // result of the previously held point, and the pending last point
   logic signed [vcea_pkg::VALUE_WIDTH-1:0] res_velocity_ff, res_velocity_in;
   logic signed [vcea_pkg::VALUE_WIDTH-1:0] res_accel_ff, res_accel_in;
   logic signed [vcea_pkg::VALUE_WIDTH-1:0] pend_velocity_ff, pend_velocity_in;
   logic                                    pend_last_ff, pend_last_in;

   // operands for the edge acceleration
   logic                                    mul_start_ff, mul_start_in;
   logic [vcea_pkg::MAG_WIDTH-1:0]          mul_a_ff, mul_a_in;
   logic [vcea_pkg::VALUE_WIDTH-1:0]        mul_b_ff, mul_b_in;
   logic [vcea_pkg::MAG_WIDTH-1:0]          den_ff, den_in;
   logic                                    neg_ff, neg_in;

   // output register
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic signed [vcea_pkg::VALUE_WIDTH-1:0] rsp_velocity_ff, rsp_velocity_in;
   logic signed [vcea_pkg::VALUE_WIDTH-1:0] rsp_accel_ff, rsp_accel_in;
   logic                                    rsp_last_ff, rsp_last_in;

   vcea_pkg::mul_ctl_type    mul_ctl;
   vcea_pkg::mul_status_type mul_status;
   vcea_pkg::div_ctl_type    div_ctl;
   vcea_pkg::div_status_type div_status;

   logic                                    accept;
   logic                                    out_free;
   logic                                    csr_write;
   logic [vcea_pkg::CSR_INDEX_WIDTH-1:0]    csr_index;
   logic                                    in_cap;
   logic                                    held_cap;
   logic signed [vcea_pkg::VALUE_WIDTH-1:0] vin_new;
   logic signed [vcea_pkg::VALUE_WIDTH-1:0] hv_new;
   logic [vcea_pkg::VALUE_WIDTH-1:0]        abs_accel;

   // |a - b| of two signed values, one bit wider
   function automatic logic [vcea_pkg::MAG_WIDTH-1:0] mag_diff(
      input logic signed [vcea_pkg::VALUE_WIDTH-1:0] a,
      input logic signed [vcea_pkg::VALUE_WIDTH-1:0] b
   );
      logic signed [vcea_pkg::MAG_WIDTH-1:0] d;
      d = vcea_pkg::MAG_WIDTH'(a) - vcea_pkg::MAG_WIDTH'(b);
      return d[vcea_pkg::MAG_WIDTH-1] ? vcea_pkg::MAG_WIDTH'(-d) : vcea_pkg::MAG_WIDTH'(d);
   endfunction

   vcea_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .mul_ctl    (mul_ctl),
      .mul_status (mul_status)
   );

   vcea_div u_div (
      .clock      (clock),
      .reset      (reset),
      .div_ctl    (div_ctl),
      .div_status (div_status)
   );

   assign mul_ctl.start        = mul_start_ff;
   assign mul_ctl.multiplicand = mul_a_ff;
   assign mul_ctl.multiplier   = mul_b_ff;

   // product stays put in the multiplier once done, so the divider takes it directly
   assign div_ctl.start    = mul_status.done;
   assign div_ctl.neg      = neg_ff;
   assign div_ctl.dividend = mul_status.product;
   assign div_ctl.divisor  = den_ff;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[vcea_pkg::CSR_ADDR_WIDTH-1:vcea_pkg::CSR_INDEX_LSB];

   always_comb begin
      cap_in = cap_ff;
      prdata = '0;
      unique case (csr_index)
         vcea_pkg::REG_VELOCITY_CAP: begin
            prdata = cap_ff;
            if (csr_write) begin
               cap_in = pwdata;
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // handshake
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // capping of the arriving and the held point
   assign in_cap    = (req_point_velocity > cap_ff);
   assign held_cap  = (held_velocity_ff > cap_ff);
   assign vin_new   = in_cap ? cap_ff : req_point_velocity;
   assign hv_new    = held_cap ? cap_ff : held_velocity_ff;
   assign abs_accel = held_accel_ff[vcea_pkg::VALUE_WIDTH-1] ? (~held_accel_ff +
                      vcea_pkg::VALUE_WIDTH'(1)) : held_accel_ff;

   always_comb begin
      state_in         = state_ff;
      held_valid_in    = held_valid_ff;
      held_velocity_in = held_velocity_ff;
      held_accel_in    = held_accel_ff;
      res_velocity_in  = res_velocity_ff;
      res_accel_in     = res_accel_ff;
      pend_velocity_in = pend_velocity_ff;
      pend_last_in     = pend_last_ff;
      mul_start_in     = 1'b0;
      mul_a_in         = mul_a_ff;
      mul_b_in         = mul_b_ff;
      den_in           = den_ff;
      neg_in           = neg_ff;
      // a taken result leaves the output register
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_velocity_in  = rsp_velocity_ff;
      rsp_accel_in     = rsp_accel_ff;
      rsp_last_in      = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_velocity_in = vin_new;
               pend_last_in     = req_point_last;
               res_velocity_in  = hv_new;
               // inside a run the acceleration drops to zero; at a run edge it is recomputed, elsewhere it is kept
               res_accel_in     = (held_cap && in_cap) ? '0 : held_accel_ff;
               mul_a_in         = mag_diff(vin_new, hv_new);
               mul_b_in         = (abs_accel == '0) ? vcea_pkg::VALUE_WIDTH'(1) : abs_accel;
               den_in           = mag_diff(req_point_velocity, held_velocity_ff);
               neg_in           = (hv_new > vin_new);

               if (held_valid_ff && (held_cap != in_cap)) begin
                  // run edge: recompute the held point's acceleration
                  mul_start_in = 1'b1;
                  state_in     = ST_MUL;
               end else if (held_valid_ff) begin
                  state_in = ST_HELD;
               end else if (req_point_last) begin
                  state_in = ST_LAST;
               end else begin
                  state_in = ST_IDLE;
               end

               if (req_point_last) begin
                  held_valid_in    = 1'b0;
                  held_velocity_in = '0;
                  held_accel_in    = '0;
               end else begin
                  held_valid_in    = 1'b1;
                  held_velocity_in = req_point_velocity;
                  held_accel_in    = req_point_accel;
               end
            end
         end
         ST_MUL: begin
            if (mul_status.done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               res_accel_in = div_status.quotient;
               state_in     = ST_HELD;
            end
         end
         ST_HELD: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_velocity_in = res_velocity_ff;
               rsp_accel_in    = res_accel_ff;
               rsp_last_in     = 1'b0;
               state_in        = pend_last_ff ? ST_LAST : ST_IDLE;
            end
         end
         ST_LAST: begin
            // final point always leaves with zero acceleration
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_velocity_in = pend_velocity_ff;
               rsp_accel_in    = '0;
               rsp_last_in     = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cap_ff        <= vcea_pkg::VALUE_MAX;
         held_valid_ff <= 1'b0;
         mul_start_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         held_valid_ff <= held_valid_in;
         mul_start_ff  <= mul_start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      held_velocity_ff <= held_velocity_in;
      held_accel_ff    <= held_accel_in;
      res_velocity_ff  <= res_velocity_in;
      res_accel_ff     <= res_accel_in;
      pend_velocity_ff <= pend_velocity_in;
      pend_last_ff     <= pend_last_in;
      mul_a_ff         <= mul_a_in;
      mul_b_ff         <= mul_b_in;
      den_ff           <= den_in;
      neg_ff           <= neg_in;
      rsp_velocity_ff  <= rsp_velocity_in;
      rsp_accel_ff     <= rsp_accel_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_velocity = rsp_velocity_ff;
   assign rsp_out_accel    = rsp_accel_ff;
   assign rsp_out_last     = rsp_last_ff;

endmodule

FILE: hw/rtl/vcea_checker.sv
// port-level checks of the velocity cap block, bound to its top level
`include "velocity_cap_with_edge_accel_core_assert.svh"

module vcea_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   req_point_last,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [vcea_pkg::VALUE_WIDTH-1:0] rsp_out_velocity,
   input logic signed [vcea_pkg::VALUE_WIDTH-1:0] rsp_out_accel,
   input logic                                   rsp_out_last
);

   // a stalled result holds
   `VCEA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_velocity) && $stable(rsp_out_accel) && $stable(rsp_out_last))

   // the final point always leaves with zero acceleration
   `VCEA_ASSERT_NOW(a_last_zero_accel, rsp_valid && rsp_out_last, rsp_out_accel == '0)

   // a last point still has to be sent out, so the next request waits
   `VCEA_ASSERT_NEXT(a_last_blocks, req_valid && !req_stall && req_point_last, req_stall)

   // out of reset the block is empty and ready
   `VCEA_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_valid && !req_stall)

endmodule

bind velocity_cap_with_edge_accel_core vcea_checker u_vcea_checker (.*);
